[src/bar_force_scatter_accumulate_assert.svh]
// Assertion macros for the bar force scatter-accumulate block.
// Needs a clk_i and an active-low rst_ni in the scope of use.
`ifndef BAR_FORCE_SCATTER_ACCUMULATE_ASSERT_SVH
`define BAR_FORCE_SCATTER_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define BFSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bfsa_pkg.sv]
// Shared types and constants of the bar force scatter-accumulate block.
// No dependencies.
`default_nettype none

package bfsa_pkg;

  localparam int NODE_W  = 10;
  localparam int FORCE_W = 32;

  localparam logic [1:0] DIM_RESET = 2'd2;
  localparam logic [1:0] DIM_3D    = 2'd3;

  typedef enum logic [1:0] {
    CMD_APPLY = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // input word
  typedef struct packed {
    logic [1:0]                command;
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic signed [FORCE_W-1:0] bar_fx;
    logic signed [FORCE_W-1:0] bar_fy;
    logic signed [FORCE_W-1:0] bar_fz;
  } bfsa_in_t;

  // result word
  typedef struct packed {
    logic [NODE_W-1:0]         out_node;
    logic signed [FORCE_W-1:0] out_fx;
    logic signed [FORCE_W-1:0] out_fy;
    logic signed [FORCE_W-1:0] out_fz;
  } bfsa_out_t;

  // one force vector as stored
  typedef struct packed {
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
  } bfsa_vec_t;

  // per-component write enables of the force store
  typedef struct packed {
    logic x;
    logic y;
    logic z;
  } bfsa_lane_t;

endpackage

`default_nettype wire

[src/bfsa_store.sv]
// Node force store: three 32-bit lanes, one write and one registered read port.
// Depends on bfsa_pkg.
`default_nettype none

module bfsa_store import bfsa_pkg::*; #(
  parameter int NODES = 1024,
  parameter int AW    = 10
) (
  input  wire logic           clk_i,
  input  wire bfsa_lane_t     we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire bfsa_vec_t      wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output bfsa_vec_t           rdata_o
);

  logic signed [FORCE_W-1:0] mem_x [NODES];
  logic signed [FORCE_W-1:0] mem_y [NODES];
  logic signed [FORCE_W-1:0] mem_z [NODES];
  bfsa_vec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.x) mem_x[waddr_i] <= wdata_i.x;
    if (we_i.y) mem_y[waddr_i] <= wdata_i.y;
    if (we_i.z) mem_z[waddr_i] <= wdata_i.z;
  end

  always_ff @(posedge clk_i) begin
    rdata_q.x <= mem_x[raddr_i];
    rdata_q.y <= mem_y[raddr_i];
    rdata_q.z <= mem_z[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/bfsa_update.sv]
// Saturating add or subtract of a bar force onto a stored node force.
// Depends on bfsa_pkg.
`default_nettype none

module bfsa_update import bfsa_pkg::*; (
  input  wire bfsa_vec_t cur_i,
  input  wire bfsa_vec_t force_i,
  input  wire logic      sub_i,
  output bfsa_vec_t      sum_o
);

  function automatic logic signed [FORCE_W-1:0] sat_add(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [FORCE_W-1:0] b,
    input logic                      sub
  );
    logic signed [FORCE_W:0] s;
    begin
      s = sub ? ((FORCE_W+1)'(a) - (FORCE_W+1)'(b))
              : ((FORCE_W+1)'(a) + (FORCE_W+1)'(b));
      // top two bits differ: out of 32-bit range, clamp toward the sign
      if (s[FORCE_W] != s[FORCE_W-1]) begin
        return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
      end
      return s[FORCE_W-1:0];
    end
  endfunction

  assign sum_o.x = sat_add(cur_i.x, force_i.x, sub_i);
  assign sum_o.y = sat_add(cur_i.y, force_i.y, sub_i);
  assign sum_o.z = sat_add(cur_i.z, force_i.z, sub_i);

endmodule

`default_nettype wire

[src/bar_force_scatter_accumulate.sv]
// Bar force scatter-accumulate: per-node force store with apply, write and read
// commands. After reset the block clears the store, one node per cycle, and holds
// busy high until every node is cleared. An apply-bar word is accepted, then does one
// read-modify-write of node_a and one of node_b through the store's single read
// port; an equal-ends apply changes no node, and a write word is stored directly. For
// reads, the read result is on result_o for exactly one cycle with result_valid_o
// high, the cycle after acceptance, and must be taken then. Words are accepted while
// start is high and busy is low. Depends on bfsa_pkg, bfsa_store, bfsa_update.
`default_nettype none

`include "bar_force_scatter_accumulate_assert.svh"

module bar_force_scatter_accumulate import bfsa_pkg::*; #(
  parameter int NODES = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire bfsa_in_t   item_i,
  output logic            result_valid_o,
  output bfsa_out_t       result_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UPD_A = 5'b00100,
    ST_UPD_B = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  bfsa_in_t        item_q, item_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [1:0]      dim_q;
  logic            three;
  logic            in_ok, a_ok, b_ok;

  bfsa_lane_t      mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  bfsa_vec_t       mem_wdata, mem_rdata, bar_vec, upd_sum;
  logic            upd_sub;

  assign three = (dim_q == DIM_3D);
  assign in_ok = (32'(item_i.node_a) < 32'(NODES));
  assign a_ok  = (32'(item_q.node_a) < 32'(NODES));
  assign b_ok  = (32'(item_q.node_b) < 32'(NODES));

  assign bar_vec = '{x: item_q.bar_fx, y: item_q.bar_fy, z: item_q.bar_fz};

  bfsa_store #(
    .NODES (NODES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfsa_update u_update (
    .cur_i   (mem_rdata),
    .force_i (bar_vec),
    .sub_i   (upd_sub),
    .sum_o   (upd_sum)
  );

  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    clr_d          = clr_q;
    mem_we         = '0;
    mem_waddr      = AW'(item_q.node_a);
    mem_wdata      = upd_sum;
    mem_raddr      = AW'(item_i.node_a);
    upd_sub        = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        mem_we    = '{x: 1'b1, y: 1'b1, z: 1'b1};
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == AW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          unique case (item_i.command)
            CMD_APPLY: begin
              if (item_i.node_a != item_i.node_b) state_d = ST_UPD_A;
            end
            CMD_WRITE: begin
              if (in_ok) begin
                mem_we    = '{x: 1'b1, y: 1'b1, z: three};
                mem_waddr = AW'(item_i.node_a);
                mem_wdata = '{x: item_i.bar_fx, y: item_i.bar_fy, z: item_i.bar_fz};
              end
            end
            CMD_READ: state_d = ST_READ;
            default: ;
          endcase
        end
      end
      ST_UPD_A: begin
        // node_a written back while node_b is fetched; the ends differ
        if (a_ok) mem_we = '{x: 1'b1, y: 1'b1, z: three};
        mem_raddr = AW'(item_q.node_b);
        state_d   = ST_UPD_B;
      end
      ST_UPD_B: begin
        if (b_ok) mem_we = '{x: 1'b1, y: 1'b1, z: three};
        mem_waddr = AW'(item_q.node_b);
        upd_sub   = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  assign result_o.out_node = item_q.node_a;
  assign result_o.out_fx   = a_ok ? mem_rdata.x : '0;
  assign result_o.out_fy   = a_ok ? mem_rdata.y : '0;
  assign result_o.out_fz   = (a_ok && three) ? mem_rdata.z : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      dim_q   <= DIM_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i) dim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  `BFSA_ASSERT_SAME(a_result_follows_read, result_valid_o,
    $past(start && !busy && item_i.command == CMD_READ), "result without a read")
  `BFSA_ASSERT_SAME(a_upd_b_after_a, state_q == ST_UPD_B,
    $past(state_q == ST_UPD_A), "second bar end updated out of order")
  `BFSA_ASSERT_SAME(a_no_z_in_2d, (state_q == ST_UPD_A || state_q == ST_UPD_B) && !three,
    !mem_we.z, "z lane written in 2-D mode")
  `BFSA_ASSERT_NEXT(a_apply_starts, start && !busy && item_i.command == CMD_APPLY &&
    item_i.node_a != item_i.node_b, state_q == ST_UPD_A, "apply word not started")

endmodule

`default_nettype wire
